>>> src/vsdc_pkg.sv
package vsdc_pkg;

  localparam int SAMPLES_PER_AXIS = 32;
  localparam int IDX_W = 5;
  localparam int ADDR_W = 15;
  localparam int DENS_W = 8;
  localparam int COORD_W = 32;
  localparam int RAD_W = 16;
  localparam int CFG_W = 16;
  localparam int CFG_IDX_W = 3;
  localparam int ROOT_W = 16;
  localparam int QUO_W = 7;
  localparam int NUM_W = 23;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_EXTENT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPACING = 3'd4;

  localparam logic [CFG_W-1:0] EXTENT_RESET = 16'd8192;
  localparam logic [CFG_W-1:0] SPACING_RESET = 16'd256;
  localparam logic [QUO_W-1:0] CARVE_MAX = 7'd127;
  localparam logic signed [DENS_W:0] DENS_MIN = -9'sd128;

  typedef struct packed {
    logic [IDX_W-1:0] sample_x;
    logic [IDX_W-1:0] sample_y;
    logic [IDX_W-1:0] sample_z;
    logic signed [DENS_W-1:0] density_in;
    logic signed [COORD_W-1:0] center_x;
    logic signed [COORD_W-1:0] center_y;
    logic signed [COORD_W-1:0] center_z;
    logic [RAD_W-1:0] sphere_radius;
  } item_t;

  typedef struct packed {
    logic signed [CFG_W-1:0] grid_x;
    logic signed [CFG_W-1:0] grid_y;
    logic signed [CFG_W-1:0] grid_z;
    logic [CFG_W-1:0] extent;
    logic [CFG_W-1:0] spacing;
  } cfg_t;

  typedef struct packed {
    logic signed [DENS_W-1:0] density;
    logic [ADDR_W-1:0] addr;
    logic touched;
    logic enclosed;
    logic [RAD_W-1:0] radius;
  } side_t;

endpackage

>>> src/vsdc_item_if.sv
interface vsdc_item_if import vsdc_pkg::*; ();
  logic valid;
  logic ready;
  logic [IDX_W-1:0] sample_x;
  logic [IDX_W-1:0] sample_y;
  logic [IDX_W-1:0] sample_z;
  logic signed [DENS_W-1:0] density_in;
  logic signed [COORD_W-1:0] center_x;
  logic signed [COORD_W-1:0] center_y;
  logic signed [COORD_W-1:0] center_z;
  logic [RAD_W-1:0] sphere_radius;

  modport source(output valid, sample_x, sample_y, sample_z, density_in, center_x, center_y,
                 center_z, sphere_radius, input ready);
  modport sink(input valid, sample_x, sample_y, sample_z, density_in, center_x, center_y,
               center_z, sphere_radius, output ready);
endinterface

>>> src/vsdc_result_if.sv
interface vsdc_result_if import vsdc_pkg::*; ();
  logic valid;
  logic ready;
  logic signed [DENS_W-1:0] density_out;
  logic [ADDR_W-1:0] sample_address;
  logic chunk_touched;
  logic carved;

  modport source(output valid, density_out, sample_address, chunk_touched, carved, input ready);
  modport sink(input valid, density_out, sample_address, chunk_touched, carved, output ready);
endinterface

>>> src/vsdc_cfg_if.sv
interface vsdc_cfg_if import vsdc_pkg::*; ();
  logic valid;
  logic ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

>>> src/vsdc_geom.sv
module vsdc_geom import vsdc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  item_t item,
  input  cfg_t cfg,
  output logic out_valid,
  output side_t side,
  output logic [31:0] pt2
);

  logic v1, v2, v3;
  logic signed [DENS_W-1:0] dens1, dens2, dens3;
  logic [RAD_W-1:0] rad1, rad2, rad3;
  logic [ADDR_W-1:0] addr1, addr2, addr3;
  logic signed [COORD_W-1:0] cen1 [3];
  logic signed [32:0] org1 [3];
  logic [20:0] off1 [3];
  logic [RAD_W-1:0] a2 [3];
  logic [RAD_W-1:0] b2 [3];
  logic fa2, fb2, fa3, fb3;
  logic [31:0] sa3 [3];
  logic [31:0] sb3 [3];
  logic [31:0] rsq3;

  logic signed [CFG_W-1:0] grid_c [3];
  logic [IDX_W-1:0] idx_c [3];
  logic signed [COORD_W-1:0] cen_c [3];
  logic signed [35:0] lo_c [3];
  logic signed [35:0] hi_c [3];
  logic signed [35:0] c_c [3];
  logic signed [35:0] cl_c [3];
  logic signed [35:0] da_c [3];
  logic signed [35:0] db_c [3];
  logic [35:0] a_c [3];
  logic [35:0] b_c [3];
  logic [2:0] fa_c, fb_c;
  logic [33:0] box_c, pt_c;
  logic [ADDR_W-1:0] addr_c;

  always_comb begin
    grid_c[0] = cfg.grid_x;
    grid_c[1] = cfg.grid_y;
    grid_c[2] = cfg.grid_z;
    idx_c[0] = item.sample_x;
    idx_c[1] = item.sample_y;
    idx_c[2] = item.sample_z;
    cen_c[0] = item.center_x;
    cen_c[1] = item.center_y;
    cen_c[2] = item.center_z;
    addr_c = ADDR_W'(32'(item.sample_y) + 32'(item.sample_x) * 32'(SAMPLES_PER_AXIS)
           + 32'(item.sample_z) * 32'(SAMPLES_PER_AXIS) * 32'(SAMPLES_PER_AXIS));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
    if (en) begin
      dens1 <= item.density_in;
      rad1 <= item.sphere_radius;
      addr1 <= addr_c;
      for (int i = 0; i < 3; i++) begin
        cen1[i] <= cen_c[i];
        org1[i] <= 33'(grid_c[i]) * $signed({17'b0, cfg.extent});
        off1[i] <= 21'(idx_c[i]) * 21'(cfg.spacing);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      lo_c[i] = 36'(org1[i]);
      hi_c[i] = lo_c[i] + $signed({20'b0, cfg.extent});
      c_c[i] = 36'(cen1[i]);
      cl_c[i] = (c_c[i] < lo_c[i]) ? lo_c[i] : ((c_c[i] > hi_c[i]) ? hi_c[i] : c_c[i]);
      da_c[i] = cl_c[i] - c_c[i];
      db_c[i] = lo_c[i] + $signed({15'b0, off1[i]}) - c_c[i];
      a_c[i] = da_c[i][35] ? 36'(-da_c[i]) : 36'(da_c[i]);
      b_c[i] = db_c[i][35] ? 36'(-db_c[i]) : 36'(db_c[i]);
      fa_c[i] = a_c[i] > {20'b0, rad1};
      fb_c[i] = b_c[i] >= {20'b0, rad1};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
      v3 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v2 <= v1;
      v3 <= v2;
      out_valid <= v3;
    end
    if (en) begin
      dens2 <= dens1;
      rad2 <= rad1;
      addr2 <= addr1;
      fa2 <= |fa_c;
      fb2 <= |fb_c;
      for (int i = 0; i < 3; i++) begin
        a2[i] <= a_c[i][RAD_W-1:0];
        b2[i] <= b_c[i][RAD_W-1:0];
      end
      dens3 <= dens2;
      rad3 <= rad2;
      addr3 <= addr2;
      fa3 <= fa2;
      fb3 <= fb2;
      rsq3 <= 32'(rad2) * 32'(rad2);
      for (int i = 0; i < 3; i++) begin
        sa3[i] <= 32'(a2[i]) * 32'(a2[i]);
        sb3[i] <= 32'(b2[i]) * 32'(b2[i]);
      end
      side.density <= dens3;
      side.addr <= addr3;
      side.radius <= rad3;
      side.touched <= !fa3 && (box_c <= 34'(rsq3));
      side.enclosed <= !fb3 && (pt_c < 34'(rsq3));
      pt2 <= pt_c[31:0];
    end
  end

  always_comb begin
    box_c = 34'(sa3[0]) + 34'(sa3[1]) + 34'(sa3[2]);
    pt_c = 34'(sb3[0]) + 34'(sb3[1]) + 34'(sb3[2]);
  end

endmodule

>>> src/vsdc_sqrt.sv
module vsdc_sqrt import vsdc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  side_t in_side,
  input  logic [31:0] n,
  output logic out_valid,
  output side_t out_side,
  output logic [ROOT_W-1:0] root
);

  logic vld [ROOT_W];
  side_t sd [ROOT_W];
  logic [31:0] rem [ROOT_W];
  logic [ROOT_W-1:0] rt [ROOT_W];

  for (genvar j = 0; j < ROOT_W; j++) begin : g_st
    localparam int K = ROOT_W - 1 - j;
    logic v_i;
    side_t s_i;
    logic [31:0] rem_i;
    logic [ROOT_W-1:0] rt_i;
    logic [32:0] trial;

    if (j == 0) begin : g_first
      assign v_i = in_valid;
      assign s_i = in_side;
      assign rem_i = n;
      assign rt_i = '0;
    end else begin : g_next
      assign v_i = vld[j-1];
      assign s_i = sd[j-1];
      assign rem_i = rem[j-1];
      assign rt_i = rt[j-1];
    end

    assign trial = (33'(rt_i) << (K + 1)) + (33'd1 << (2 * K));

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j] <= 1'b0;
      end else if (en) begin
        vld[j] <= v_i;
      end
      if (en) begin
        sd[j] <= s_i;
        if ({1'b0, rem_i} >= trial) begin
          rem[j] <= 32'({1'b0, rem_i} - trial);
          rt[j] <= rt_i | (ROOT_W'(1) << K);
        end else begin
          rem[j] <= rem_i;
          rt[j] <= rt_i;
        end
      end
    end
  end

  assign out_valid = vld[ROOT_W-1];
  assign out_side = sd[ROOT_W-1];
  assign root = rt[ROOT_W-1];

endmodule

>>> src/vsdc_div.sv
module vsdc_div import vsdc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  side_t in_side,
  input  logic [ROOT_W-1:0] root,
  output logic out_valid,
  output side_t out_side,
  output logic [QUO_W-1:0] quo
);

  logic v0;
  side_t s0;
  logic [NUM_W-1:0] num0;

  logic vld [QUO_W];
  side_t sd [QUO_W];
  logic [NUM_W-1:0] rem [QUO_W];
  logic [QUO_W-1:0] q [QUO_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= in_valid;
    end
    if (en) begin
      s0 <= in_side;
      num0 <= NUM_W'(CARVE_MAX) * NUM_W'(in_side.radius - root);
    end
  end

  for (genvar j = 0; j < QUO_W; j++) begin : g_st
    localparam int K = QUO_W - 1 - j;
    logic v_i;
    side_t s_i;
    logic [NUM_W-1:0] rem_i;
    logic [QUO_W-1:0] q_i;
    logic [NUM_W-1:0] dv;

    if (j == 0) begin : g_first
      assign v_i = v0;
      assign s_i = s0;
      assign rem_i = num0;
      assign q_i = '0;
    end else begin : g_next
      assign v_i = vld[j-1];
      assign s_i = sd[j-1];
      assign rem_i = rem[j-1];
      assign q_i = q[j-1];
    end

    assign dv = NUM_W'(s_i.radius) << K;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j] <= 1'b0;
      end else if (en) begin
        vld[j] <= v_i;
      end
      if (en) begin
        sd[j] <= s_i;
        if (rem_i >= dv) begin
          rem[j] <= rem_i - dv;
          q[j] <= q_i | (QUO_W'(1) << K);
        end else begin
          rem[j] <= rem_i;
          q[j] <= q_i;
        end
      end
    end
  end

  assign out_valid = vld[QUO_W-1];
  assign out_side = sd[QUO_W-1];
  assign quo = q[QUO_W-1];

endmodule

>>> src/voxel_sphere_density_carve_unit.sv
// Item accept to result valid runs through 4 geometry, 16 root, 8 divide and 1 output register stages.
// Throughput: one item per cycle while the output is not stalled; the root and divide units retire one bit per stage.
// The whole pipeline advances when the output register is empty or taken.
// Reset: synchronous, clears all valid bits and loads register defaults
// (grid 0, extent 8192, spacing 256).
module voxel_sphere_density_carve_unit import vsdc_pkg::*; (
  input  logic clk,
  input  logic rst,
  vsdc_item_if.sink items,
  vsdc_result_if.source results,
  vsdc_cfg_if.sink cfg
);

  cfg_t regs;
  item_t item;
  logic en;
  logic g_valid, s_valid, d_valid;
  side_t g_side, s_side, d_side;
  logic [31:0] pt2;
  logic [ROOT_W-1:0] root;
  logic [QUO_W-1:0] quo;
  logic signed [DENS_W:0] diff;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.grid_x <= '0;
      regs.grid_y <= '0;
      regs.grid_z <= '0;
      regs.extent <= EXTENT_RESET;
      regs.spacing <= SPACING_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_GRID_X: regs.grid_x <= cfg.data;
        REG_GRID_Y: regs.grid_y <= cfg.data;
        REG_GRID_Z: regs.grid_z <= cfg.data;
        REG_EXTENT: regs.extent <= cfg.data;
        REG_SPACING: regs.spacing <= cfg.data;
        default: ;
      endcase
    end
  end

  assign en = !results.valid || results.ready;
  assign items.ready = en;

  always_comb begin
    item.sample_x = items.sample_x;
    item.sample_y = items.sample_y;
    item.sample_z = items.sample_z;
    item.density_in = items.density_in;
    item.center_x = items.center_x;
    item.center_y = items.center_y;
    item.center_z = items.center_z;
    item.sphere_radius = items.sphere_radius;
  end

  vsdc_geom u_geom (
    .clk(clk), .rst(rst), .en(en), .in_valid(items.valid), .item(item), .cfg(regs),
    .out_valid(g_valid), .side(g_side), .pt2(pt2)
  );

  vsdc_sqrt u_sqrt (
    .clk(clk), .rst(rst), .en(en), .in_valid(g_valid), .in_side(g_side), .n(pt2),
    .out_valid(s_valid), .out_side(s_side), .root(root)
  );

  vsdc_div u_div (
    .clk(clk), .rst(rst), .en(en), .in_valid(s_valid), .in_side(s_side), .root(root),
    .out_valid(d_valid), .out_side(d_side), .quo(quo)
  );

  assign diff = 9'(d_side.density) - $signed({2'b0, quo});

  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (en) begin
      results.valid <= d_valid;
    end
    if (en) begin
      results.sample_address <= d_side.addr;
      results.chunk_touched <= d_side.touched;
      results.carved <= d_side.touched && d_side.enclosed;
      if (d_side.touched && d_side.enclosed) begin
        results.density_out <= (diff < DENS_MIN) ? DENS_MIN[DENS_W-1:0] : diff[DENS_W-1:0];
      end else begin
        results.density_out <= d_side.density;
      end
    end
  end

  a_carved_touched: assert property (@(posedge clk) disable iff (rst)
    results.valid |-> (!results.carved || results.chunk_touched))
    else $error("carved result without chunk contact");

  a_ready_follows_out: assert property (@(posedge clk) disable iff (rst)
    items.ready == (!results.valid || results.ready))
    else $error("input ready does not track output stall");

  a_reset_clears: assert property (@(posedge clk)
    $past(rst) |-> !results.valid)
    else $error("result valid after reset");

endmodule
